// ===== sv/fpcr_pkg.sv =====
// Shared constants, types and helpers of the fixed-point channel rematrix block.
package fpcr_pkg;

  // Matrix size
  localparam int unsigned MAX_CHANNELS = 32;
  localparam int unsigned CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CNT_W        = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned COEF_AW      = 2 * CH_W;
  localparam int unsigned COEF_DEPTH   = 1 << COEF_AW;
  localparam int unsigned FB_DEPTH     = 1 << CH_W;

  // Field widths
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned COEF_W     = 17;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned CFG_IDX_W  = 2;

  // Datapath widths
  localparam int unsigned PROD_W    = COEF_W + SAMPLE_W;
  localparam int unsigned ACC_W     = PROD_W + CH_W;
  localparam int unsigned FRAC_BITS = 15;
  localparam int unsigned RND_W     = ACC_W - FRAC_BITS;

  localparam int unsigned ROUND_BIAS = 16384;
  localparam logic [SAMPLE_W-1:0] SAT_MAX = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] SAT_MIN = 16'h8000;

  // Stream widths
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_CHANNELS  = 2'd0,
    REG_OUT_CHANNELS = 2'd1,
    REG_SATURATE     = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN
  } state_e;

  // zero counts as one, anything above the matrix size as the matrix size
  function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_DATA_W-1:0] c);
    logic [CFG_DATA_W:0] w;
    logic [CFG_DATA_W:0] mx;
    w  = {1'b0, c};
    mx = (CFG_DATA_W + 1)'(MAX_CHANNELS);
    if (w == '0) begin
      return CNT_W'(1);
    end else if (w > mx) begin
      return CNT_W'(MAX_CHANNELS);
    end else begin
      return CNT_W'(w);
    end
  endfunction

endpackage

// ===== sv/fpcr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fpcr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fixed_point_channel_rematrix_top.sv =====
// Fixed-point channel rematrix: coefficient store, frame buffer and shared MAC sequencer.
//
// Mixes interleaved signed 16-bit frames through a 32x32 matrix of signed 17.15
// coefficients using one shared multiplier and accumulator. After reset the block
// zeroes all 1024 coefficient RAM entries (one entry per cycle) with s_axis_tready
// low; configuration writes are taken throughout. After a load or a sample that
// does not end a frame the block stays ready for the next item. A sample that ends
// a frame starts the MAC sequencer, which walks each output row over in_channels
// terms at one term per cycle, each term passing through the RAM-read, multiply and
// accumulate registers; a finished row waits while the output register is full.
// Results leave through an output register, so the last result of a frame may wait
// while the next items are already accepted.
module fixed_point_channel_rematrix_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // coeff_out_index[4:0], coeff_in_index[9:5], coeff_value[26:10], sample[42:27]
  input  logic [fpcr_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  // action
  input  logic                              s_axis_tuser_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // mixed_sample[15:0], out_channel[20:16]
  output logic [fpcr_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                              m_axis_tlast_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fpcr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fpcr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned POS_W = fpcr_pkg::IDX_W + 1;

  // configuration
  logic [fpcr_pkg::CFG_DATA_W-1:0] in_ch_q, out_ch_q;
  logic                            sat_q;

  // sequencer
  fpcr_pkg::state_e                state_q, state_d;
  logic [fpcr_pkg::COEF_AW-1:0]    clr_q, clr_d;
  logic [fpcr_pkg::IDX_W-1:0]      pos_q, pos_d;
  logic [fpcr_pkg::CH_W-1:0]       i_q, i_d, o_q, o_d;
  logic                            s1_q, s2_q;
  logic signed [fpcr_pkg::PROD_W-1:0] prod_q, prod_d;
  logic signed [fpcr_pkg::ACC_W-1:0]  acc_q, acc_d;

  // output register
  logic                            out_vld_q, out_vld_d;
  logic [fpcr_pkg::SAMPLE_W-1:0]   out_smp_q, out_smp_d;
  logic [fpcr_pkg::IDX_W-1:0]      out_ch_idx_q, out_ch_idx_d;
  logic                            out_last_q, out_last_d;

  // input fields
  fpcr_pkg::action_e               act;
  logic [fpcr_pkg::IDX_W-1:0]      row, col;
  logic [fpcr_pkg::COEF_W-1:0]     cval;
  logic [fpcr_pkg::SAMPLE_W-1:0]   smp;

  logic [fpcr_pkg::CNT_W-1:0]      n_in, n_out;
  logic                            in_acc, frame_end, row_ok, col_ok, pos_ok;
  logic                            i_last, o_last, issue, out_free;

  // RAM ports
  logic                            coef_we;
  logic [fpcr_pkg::COEF_AW-1:0]    coef_waddr;
  logic [fpcr_pkg::COEF_W-1:0]     coef_wdata, coef_rdata;
  logic                            fb_we;
  logic [fpcr_pkg::SAMPLE_W-1:0]   fb_rdata;

  // rounding
  logic signed [fpcr_pkg::ACC_W-1:0] rsum;
  logic [fpcr_pkg::RND_W-1:0]        rnd;
  logic                              pos_ovf, neg_ovf;
  logic [fpcr_pkg::SAMPLE_W-1:0]     mixed;

  assign act  = fpcr_pkg::action_e'(s_axis_tuser_i);
  assign row  = s_axis_tdata_i[4:0];
  assign col  = s_axis_tdata_i[9:5];
  assign cval = s_axis_tdata_i[26:10];
  assign smp  = s_axis_tdata_i[42:27];

  assign n_in  = fpcr_pkg::eff_count(in_ch_q);
  assign n_out = fpcr_pkg::eff_count(out_ch_q);

  assign s_axis_tready_o = (state_q == fpcr_pkg::ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  assign row_ok = {1'b0, row} < POS_W'(fpcr_pkg::MAX_CHANNELS);
  assign col_ok = {1'b0, col} < POS_W'(fpcr_pkg::MAX_CHANNELS);
  assign pos_ok = {1'b0, pos_q} < POS_W'(fpcr_pkg::MAX_CHANNELS);
  assign frame_end = ({1'b0, pos_q} + POS_W'(1)) >= POS_W'(n_in);

  assign i_last = (fpcr_pkg::CNT_W'(i_q) + fpcr_pkg::CNT_W'(1)) == n_in;
  assign o_last = (fpcr_pkg::CNT_W'(o_q) + fpcr_pkg::CNT_W'(1)) == n_out;
  assign issue  = (state_q == fpcr_pkg::ST_MAC);
  assign out_free = !out_vld_q || m_axis_tready_i;

  // clearing pass owns the write port until it is done
  always_comb begin
    coef_we    = 1'b0;
    coef_waddr = clr_q;
    coef_wdata = '0;
    if (state_q == fpcr_pkg::ST_CLEAR) begin
      coef_we = 1'b1;
    end else if (in_acc && act == fpcr_pkg::ACT_LOAD && row_ok && col_ok) begin
      coef_we    = 1'b1;
      coef_waddr = {row[fpcr_pkg::CH_W-1:0], col[fpcr_pkg::CH_W-1:0]};
      coef_wdata = cval;
    end
  end

  assign fb_we = in_acc && act == fpcr_pkg::ACT_SAMPLE && pos_ok;

  fpcr_ram #(
    .WIDTH (fpcr_pkg::COEF_W),
    .DEPTH (fpcr_pkg::COEF_DEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_wdata),
    .raddr_i ({o_q, i_q}),
    .rdata_o (coef_rdata)
  );

  fpcr_ram #(
    .WIDTH (fpcr_pkg::SAMPLE_W),
    .DEPTH (fpcr_pkg::FB_DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fb_we),
    .waddr_i (pos_q[fpcr_pkg::CH_W-1:0]),
    .wdata_i (smp),
    .raddr_i (i_q),
    .rdata_o (fb_rdata)
  );

  assign prod_d = $signed(coef_rdata) * $signed(fb_rdata);

  // round half up, then clip or wrap
  always_comb begin
    rsum    = acc_q + $signed(fpcr_pkg::ACC_W'(fpcr_pkg::ROUND_BIAS));
    rnd     = rsum[fpcr_pkg::ACC_W-1:fpcr_pkg::FRAC_BITS];
    pos_ovf = !rnd[fpcr_pkg::RND_W-1] && (|rnd[fpcr_pkg::RND_W-2:fpcr_pkg::SAMPLE_W-1]);
    neg_ovf = rnd[fpcr_pkg::RND_W-1] && !(&rnd[fpcr_pkg::RND_W-2:fpcr_pkg::SAMPLE_W-1]);
    mixed   = rnd[fpcr_pkg::SAMPLE_W-1:0];
    if (sat_q && pos_ovf) begin
      mixed = fpcr_pkg::SAT_MAX;
    end else if (sat_q && neg_ovf) begin
      mixed = fpcr_pkg::SAT_MIN;
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    pos_d        = pos_q;
    i_d          = i_q;
    o_d          = o_q;
    acc_d        = acc_q;
    out_vld_d    = out_vld_q && !m_axis_tready_i;
    out_smp_d    = out_smp_q;
    out_ch_idx_d = out_ch_idx_q;
    out_last_d   = out_last_q;

    if (s2_q) begin
      acc_d = acc_q + fpcr_pkg::ACC_W'(prod_q);
    end

    unique case (state_q)
      fpcr_pkg::ST_CLEAR: begin
        clr_d = clr_q + fpcr_pkg::COEF_AW'(1);
        if (&clr_q) begin
          state_d = fpcr_pkg::ST_IDLE;
        end
      end
      fpcr_pkg::ST_IDLE: begin
        if (in_acc && act == fpcr_pkg::ACT_SAMPLE) begin
          if (frame_end) begin
            pos_d   = '0;
            i_d     = '0;
            o_d     = '0;
            acc_d   = '0;
            state_d = fpcr_pkg::ST_MAC;
          end else begin
            pos_d = pos_q + fpcr_pkg::IDX_W'(1);
          end
        end
      end
      fpcr_pkg::ST_MAC: begin
        i_d = i_q + fpcr_pkg::CH_W'(1);
        if (i_last) begin
          state_d = fpcr_pkg::ST_DRAIN;
        end
      end
      fpcr_pkg::ST_DRAIN: begin
        // row sum is final once both latency stages are empty
        if (!s1_q && !s2_q && out_free) begin
          out_vld_d    = 1'b1;
          out_smp_d    = mixed;
          out_ch_idx_d = fpcr_pkg::IDX_W'(o_q);
          out_last_d   = o_last;
          acc_d        = '0;
          i_d          = '0;
          o_d          = o_q + fpcr_pkg::CH_W'(1);
          state_d      = o_last ? fpcr_pkg::ST_IDLE : fpcr_pkg::ST_MAC;
        end
      end
      default: begin
        state_d = fpcr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fpcr_pkg::ST_CLEAR;
      clr_q     <= '0;
      pos_q     <= '0;
      i_q       <= '0;
      o_q       <= '0;
      s1_q      <= 1'b0;
      s2_q      <= 1'b0;
      out_vld_q <= 1'b0;
      in_ch_q   <= fpcr_pkg::CFG_DATA_W'(2);
      out_ch_q  <= fpcr_pkg::CFG_DATA_W'(2);
      sat_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      pos_q     <= pos_d;
      i_q       <= i_d;
      o_q       <= o_d;
      s1_q      <= issue;
      s2_q      <= s1_q;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (fpcr_pkg::cfg_reg_e'(cfg_index_i))
          fpcr_pkg::REG_IN_CHANNELS:  in_ch_q  <= cfg_data_i;
          fpcr_pkg::REG_OUT_CHANNELS: out_ch_q <= cfg_data_i;
          fpcr_pkg::REG_SATURATE:     sat_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q       <= prod_d;
    acc_q        <= acc_d;
    out_smp_q    <= out_smp_d;
    out_ch_idx_q <= out_ch_idx_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {3'b000, out_ch_idx_q, out_smp_q};

endmodule

// ===== sv/fpcr_chk.sv =====
// Port-level checker for the channel rematrix top level, with its bind.
module fpcr_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic [fpcr_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  input logic                            s_axis_tuser_i,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [fpcr_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  input logic                            m_axis_tlast_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [fpcr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [fpcr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // coefficient clear runs right after reset
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready_o)
    else $error("input ready during coefficient clear");

  // handshake outputs are always driven once out of reset
  a_known_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({s_axis_tready_o, m_axis_tvalid_o, cfg_ready_o}))
    else $error("unknown handshake output");

  // a fresh result that does not end a frame never carries channel 31
  a_first_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) && !m_axis_tlast_o && $past(!s_axis_tready_o) |->
      m_axis_tdata_o[20:16] != 5'd31)
    else $error("bad output channel index");

endmodule

bind fixed_point_channel_rematrix_top fpcr_chk u_fpcr_chk (.*);

// ===== dv/fixed_point_channel_rematrix_top_test.sv =====
// Self-checking testbench for fixed_point_channel_rematrix_top: random and directed mixing.
`timescale 1ns / 100ps

module fixed_point_channel_rematrix_top_test;

  localparam int unsigned RUN_LIMIT     = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef struct {
    fpcr_pkg::action_e                   action;
    logic [fpcr_pkg::IDX_W-1:0]          row;
    logic [fpcr_pkg::IDX_W-1:0]          col;
    logic signed [fpcr_pkg::COEF_W-1:0]  coef;
    logic signed [fpcr_pkg::SAMPLE_W-1:0] smp;
  } feed_item_t;

  typedef struct {
    logic [fpcr_pkg::SAMPLE_W-1:0] mixed;
    logic [fpcr_pkg::IDX_W-1:0]    chan;
    logic                          last;
  } mix_result_t;

  logic                             clk_i = 1'b0;
  logic                             rst_n = 1'b0;
  logic [fpcr_pkg::S_TDATA_W-1:0]   s_tdata = '0;
  logic                             s_tuser = 1'b0;
  logic                             s_valid = 1'b0;
  logic                             s_ready;
  logic [fpcr_pkg::M_TDATA_W-1:0]   m_tdata;
  logic                             m_tlast;
  logic                             m_valid;
  logic                             m_ready = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [fpcr_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [fpcr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  fixed_point_channel_rematrix_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stimulus and expected mixes
  feed_item_t  feed_q[$];
  feed_item_t  offered;
  mix_result_t pending_mixes[$];

  // shadow of the mixer state
  logic signed [fpcr_pkg::COEF_W-1:0]
    coef_mem [fpcr_pkg::MAX_CHANNELS][fpcr_pkg::MAX_CHANNELS];
  logic signed [fpcr_pkg::SAMPLE_W-1:0] frame_mem [fpcr_pkg::MAX_CHANNELS];
  logic [fpcr_pkg::IDX_W-1:0]           frame_pos = '0;
  logic [fpcr_pkg::CFG_DATA_W-1:0]      cfg_in_ch = 5'd2;
  logic [fpcr_pkg::CFG_DATA_W-1:0]      cfg_out_ch = 5'd2;
  logic                                 cfg_sat = 1'b0;

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  function automatic int chan_count(input logic [fpcr_pkg::CFG_DATA_W-1:0] c);
    return (c == '0) ? 1 : int'(c);
  endfunction

  // advance the shadow state by one accepted item, queue the mixes it produces
  function automatic void mix_model(input feed_item_t it);
    int          n_in;
    int          n_out;
    longint      acc;
    longint      r;
    mix_result_t res;
    if (it.action == fpcr_pkg::ACT_LOAD) begin
      coef_mem[it.row][it.col] = it.coef;
      return;
    end
    n_in = chan_count(cfg_in_ch);
    frame_mem[frame_pos] = it.smp;
    if (int'(frame_pos) + 1 < n_in) begin
      frame_pos = frame_pos + 1'b1;
      return;
    end
    frame_pos = '0;
    n_out = chan_count(cfg_out_ch);
    for (int o = 0; o < n_out; o++) begin
      acc = 0;
      for (int i = 0; i < n_in; i++) begin
        acc += longint'(coef_mem[o][i]) * longint'(frame_mem[i]);
      end
      r = (acc + 64'sd16384) >>> 15;
      if (cfg_sat) begin
        if (r > 64'sd32767) r = 64'sd32767;
        if (r < -64'sd32768) r = -64'sd32768;
      end
      res.mixed = r[fpcr_pkg::SAMPLE_W-1:0];
      res.chan  = o[fpcr_pkg::IDX_W-1:0];
      res.last  = (o == n_out - 1);
      pending_mixes.push_back(res);
    end
  endfunction

  // source side
  always @(posedge clk_i) begin
    if (!rst_n) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        mix_model(offered);
      end
      if (!s_valid || s_ready) begin
        if (feed_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          offered = feed_q.pop_front();
          s_tdata <= {5'd0, offered.smp, offered.coef, offered.col, offered.row};
          s_tuser <= offered.action;
          s_valid <= 1'b1;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // sink backpressure, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      m_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_ready   <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // output checker
  always @(posedge clk_i) begin
    mix_result_t want;
    if (rst_n && m_valid && m_ready) begin
      if (pending_mixes.size() == 0) begin
        $display("%0t: unexpected transaction tdata=%h tlast=%b", $time, m_tdata, m_tlast);
        fail_count++;
      end else begin
        want = pending_mixes.pop_front();
        if (m_tdata[15:0] !== want.mixed) begin
          $display("%0t: mixed_sample expected %h actual %h", $time, want.mixed, m_tdata[15:0]);
          fail_count++;
        end
        if (m_tdata[20:16] !== want.chan) begin
          $display("%0t: out_channel expected %0d actual %0d", $time, want.chan, m_tdata[20:16]);
          fail_count++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last_of_frame expected %b actual %b", $time, want.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("fixed_point_channel_rematrix_top regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input fpcr_pkg::cfg_reg_e idx,
                           input logic [fpcr_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      fpcr_pkg::REG_IN_CHANNELS:  cfg_in_ch = val;
      fpcr_pkg::REG_OUT_CHANNELS: cfg_out_ch = val;
      default:                    cfg_sat = val[0];
    endcase
  endtask

  // wait until nothing is in flight, then let the mixer settle
  task automatic drain_mixes();
    do @(negedge clk_i); while (feed_q.size() != 0 || s_valid || pending_mixes.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_coef(input int row, input int col, input int val, input int smp = 0);
    feed_item_t it;
    it.action = fpcr_pkg::ACT_LOAD;
    it.row    = row[fpcr_pkg::IDX_W-1:0];
    it.col    = col[fpcr_pkg::IDX_W-1:0];
    it.coef   = val[fpcr_pkg::COEF_W-1:0];
    it.smp    = smp[fpcr_pkg::SAMPLE_W-1:0];
    feed_q.push_back(it);
  endtask

  task automatic put_sample(input int val);
    feed_item_t it;
    it.action = fpcr_pkg::ACT_SAMPLE;
    it.row    = 5'($urandom());
    it.col    = 5'($urandom());
    it.coef   = 17'($urandom());
    it.smp    = val[fpcr_pkg::SAMPLE_W-1:0];
    feed_q.push_back(it);
  endtask

  function automatic int pick_coef();
    case ($urandom_range(0, 7))
      0:       return -32768;
      1:       return 32768;
      default: return int'($urandom_range(0, 65536)) - 32768;
    endcase
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(0, 7))
      0:       return -32768;
      1:       return 32767;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic run_phase(input int n_in, input int n_out, input int sat, input int src_pct,
                           input int snk_pct, input int n_items, input int load_pct,
                           input bit hold_off);
    int row;
    int col;
    drain_mixes();
    write_reg(fpcr_pkg::REG_IN_CHANNELS, n_in[fpcr_pkg::CFG_DATA_W-1:0]);
    write_reg(fpcr_pkg::REG_OUT_CHANNELS, n_out[fpcr_pkg::CFG_DATA_W-1:0]);
    write_reg(fpcr_pkg::REG_SATURATE, sat[fpcr_pkg::CFG_DATA_W-1:0]);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < load_pct) begin
        // mostly coefficients that take part in the mix
        if ($urandom_range(0, 9) < 7) begin
          row = $urandom_range(0, chan_count(n_out[4:0]) - 1);
          col = $urandom_range(0, chan_count(n_in[4:0]) - 1);
        end else begin
          row = $urandom_range(0, 31);
          col = $urandom_range(0, 31);
        end
        load_coef(row, col, pick_coef(), pick_sample());
      end else begin
        put_sample(pick_sample());
      end
    end
    if (hold_off) begin
      @(negedge clk_i);
      hold_reqs++;
    end
    drain_mixes();
  endtask

  initial begin
    for (int r = 0; r < fpcr_pkg::MAX_CHANNELS; r++) begin
      frame_mem[r] = '0;
      for (int c = 0; c < fpcr_pkg::MAX_CHANNELS; c++) coef_mem[r][c] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;

    // directed: unity and extreme coefficients, wrap and clip
    load_coef(0, 0, 32768);
    load_coef(0, 1, 32768);
    load_coef(1, 0, -32768);
    load_coef(1, 1, -1, -32768);
    put_sample(32767);
    put_sample(32767);
    put_sample(-32768);
    put_sample(0);
    drain_mixes();
    write_reg(fpcr_pkg::REG_SATURATE, 5'd1);
    put_sample(-32768);
    put_sample(-32768);
    load_coef(31, 31, 12345, 32767);
    drain_mixes();
    // zero counts behave as one channel
    write_reg(fpcr_pkg::REG_IN_CHANNELS, 5'd0);
    write_reg(fpcr_pkg::REG_OUT_CHANNELS, 5'd0);
    put_sample(20000);
    drain_mixes();
    // in_channels shrinks mid-frame: frame closes on the next sample
    write_reg(fpcr_pkg::REG_IN_CHANNELS, 5'd3);
    write_reg(fpcr_pkg::REG_OUT_CHANNELS, 5'd1);
    write_reg(fpcr_pkg::REG_SATURATE, 5'd0);
    put_sample(100);
    put_sample(-200);
    drain_mixes();
    write_reg(fpcr_pkg::REG_IN_CHANNELS, 5'd1);
    put_sample(7);
    drain_mixes();
    // in_channels grows mid-frame
    write_reg(fpcr_pkg::REG_IN_CHANNELS, 5'd2);
    write_reg(fpcr_pkg::REG_OUT_CHANNELS, 5'd2);
    put_sample(5);
    drain_mixes();
    write_reg(fpcr_pkg::REG_IN_CHANNELS, 5'd4);
    write_reg(fpcr_pkg::REG_OUT_CHANNELS, 5'd3);
    put_sample(-32768);
    put_sample(32767);
    put_sample(-9);

    // random phases
    run_phase(3, 4, 1, 0, 0, 24, 25, 1'b0);
    run_phase(5, 2, 0, 79, 0, 24, 25, 1'b0);
    run_phase(2, 6, 1, 0, 79, 24, 25, 1'b0);
    run_phase(31, 31, 0, 12, 12, 42, 10, 1'b0);
    run_phase(2, 4, 1, 0, 0, 40, 20, 1'b1);
    run_phase($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(0, 1),
              12, 12, 24, 25, 1'b0);
    run_phase(1, 31, 1, 79, 0, 24, 25, 1'b0);
    drain_mixes();

    if (fail_count == 0 && pending_mixes.size() == 0) begin
      $display("fixed_point_channel_rematrix_top regression: pass");
    end else begin
      $display("fixed_point_channel_rematrix_top regression: fail");
    end
    $finish;
  end

endmodule
